[hdl/mwfp_pkg.sv]
package mwfp_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned FRAME_W  = 16;
  localparam int unsigned FILL_W   = 2;
  localparam int unsigned FIDX_W   = 2;

  localparam logic [FILL_W-1:0] FILL_FULL  = 2'd3;
  localparam logic [FIDX_W-1:0] FIDX_LAST  = 2'd3;
  localparam logic [WORD_W-1:0] SYNC_RESET = '0;

  typedef enum logic [2:0] {
    PH_SEARCH  = 3'd0,
    PH_COUNT   = 3'd1,
    PH_SOURCE  = 3'd2,
    PH_KIND    = 3'd3,
    PH_LENGTH  = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  payload_byte;
    logic               has_data;
    logic               frame_end;
    logic [FRAME_W-1:0] frame_number;
    logic [BYTE_W-1:0]  source;
    logic [BYTE_W-1:0]  kind;
    logic [WORD_W-1:0]  frames_done;
  } result_t;

  typedef struct packed {
    logic in_valid;
    logic step;
  } step_ctrl_t;

endpackage

[hdl/mwfp_if.sv]
interface mwfp_byte_if;
  import mwfp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface mwfp_result_if;
  import mwfp_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  payload_byte;
  logic               has_data;
  logic               frame_end;
  logic [FRAME_W-1:0] frame_number;
  logic [BYTE_W-1:0]  source_id;
  logic [BYTE_W-1:0]  kind;
  logic [WORD_W-1:0]  frames_done;

  modport source (
    output valid, output payload_byte, output has_data, output frame_end,
    output frame_number, output source_id, output kind, output frames_done,
    input ready
  );
  modport sink (
    input valid, input payload_byte, input has_data, input frame_end,
    input frame_number, input source_id, input kind, input frames_done,
    output ready
  );
endinterface

[hdl/mwfp_in_stage.sv]
module mwfp_in_stage
  import mwfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  mwfp_byte_if.sink         in_ch,
  input  logic              step,
  output logic              valid_r,
  output logic [BYTE_W-1:0] data_r
);

  logic take;

  assign in_ch.ready = !valid_r || step;
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (step) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_ch.data_byte;
    end
  end

endmodule

[hdl/mwfp_parser.sv]
module mwfp_parser
  import mwfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  step_ctrl_t        ctrl,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic [WORD_W-1:0] sync_word,
  output logic              res_valid,
  output result_t           res
);

  phase_t             phase_r, phase_nxt;
  logic [WORD_W-1:0]  window_r, window_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [FIDX_W-1:0]  fidx_r, fidx_nxt;
  logic [FRAME_W-1:0] frame_number_r, frame_number_nxt;
  logic [BYTE_W-1:0]  source_r, source_nxt;
  logic [BYTE_W-1:0]  kind_r, kind_nxt;
  logic [WORD_W-1:0]  remaining_r, remaining_nxt;
  logic [WORD_W-1:0]  frame_count_r, frame_count_nxt;

  logic [WORD_W-1:0]  window_shift;
  logic [WORD_W-1:0]  length_acc;
  logic [WORD_W-1:0]  remaining_dec;
  logic [WORD_W-1:0]  count_inc;

  assign window_shift  = {data_byte, window_r[WORD_W-1:BYTE_W]};
  assign length_acc    = remaining_r | ({{(WORD_W-BYTE_W){1'b0}}, data_byte}
                                        << {fidx_r, 3'b000});
  assign remaining_dec = remaining_r - WORD_W'(1);
  assign count_inc     = frame_count_r + WORD_W'(1);

  always_comb begin
    phase_nxt        = phase_r;
    window_nxt       = window_r;
    fill_nxt         = fill_r;
    fidx_nxt         = fidx_r;
    frame_number_nxt = frame_number_r;
    source_nxt       = source_r;
    kind_nxt         = kind_r;
    remaining_nxt    = remaining_r;
    frame_count_nxt  = frame_count_r;
    res_valid        = 1'b0;
    res.payload_byte = '0;
    res.has_data     = 1'b0;
    res.frame_end    = 1'b0;
    res.frame_number = frame_number_r;
    res.source       = source_r;
    res.kind         = kind_r;
    res.frames_done  = frame_count_r;

    unique case (phase_r)
      PH_COUNT: begin
        if (fidx_r == '0) begin
          frame_number_nxt = {{(FRAME_W-BYTE_W){1'b0}}, data_byte};
          fidx_nxt         = FIDX_W'(1);
        end else begin
          frame_number_nxt = {data_byte, frame_number_r[BYTE_W-1:0]};
          fidx_nxt         = '0;
          phase_nxt        = PH_SOURCE;
        end
      end
      PH_SOURCE: begin
        source_nxt = data_byte;
        phase_nxt  = PH_KIND;
      end
      PH_KIND: begin
        kind_nxt  = data_byte;
        phase_nxt = PH_LENGTH;
        fidx_nxt  = '0;
      end
      PH_LENGTH: begin
        remaining_nxt = (fidx_r == '0) ? {{(WORD_W-BYTE_W){1'b0}}, data_byte}
                                       : length_acc;
        if (fidx_r != FIDX_LAST) begin
          fidx_nxt = fidx_r + FIDX_W'(1);
        end else begin
          fidx_nxt = '0;
          if (length_acc == '0) begin
            frame_count_nxt = count_inc;
            res_valid       = ctrl.in_valid;
            res.frame_end   = 1'b1;
            res.frames_done = count_inc;
            window_nxt      = '0;
            fill_nxt        = '0;
            phase_nxt       = PH_SEARCH;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        remaining_nxt    = remaining_dec;
        res_valid        = ctrl.in_valid;
        res.payload_byte = data_byte;
        res.has_data     = 1'b1;
        if (remaining_dec == '0) begin
          frame_count_nxt = count_inc;
          res.frame_end   = 1'b1;
          res.frames_done = count_inc;
          window_nxt      = '0;
          fill_nxt        = '0;
          fidx_nxt        = '0;
          phase_nxt       = PH_SEARCH;
        end
      end
      default: begin
        window_nxt = window_shift;
        phase_nxt  = PH_SEARCH;
        if (fill_r != FILL_FULL) begin
          fill_nxt = fill_r + FILL_W'(1);
        end else if (window_shift == sync_word) begin
          window_nxt = '0;
          fill_nxt   = '0;
          fidx_nxt   = '0;
          phase_nxt  = PH_COUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_SEARCH;
      fill_r        <= '0;
      fidx_r        <= '0;
      frame_count_r <= '0;
    end else if (ctrl.step) begin
      phase_r       <= phase_nxt;
      fill_r        <= fill_nxt;
      fidx_r        <= fidx_nxt;
      frame_count_r <= frame_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      window_r       <= window_nxt;
      frame_number_r <= frame_number_nxt;
      source_r       <= source_nxt;
      kind_r         <= kind_nxt;
      remaining_r    <= remaining_nxt;
    end
  end

  // A payload phase always has at least one byte left to deliver.
  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> remaining_r != '0)
    else $error("payload phase with no bytes remaining");

  // The window is emptied whenever the hunt is not running.
  a_fill_idle: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_SEARCH |-> fill_r == '0)
    else $error("window holds bytes outside the hunt");

  // A result without data is only ever an end marker.
  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.has_data |-> res.frame_end)
    else $error("empty result that does not end a frame");

  // The frame counter moves only when a frame is completed.
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.step && res_valid && res.frame_end) |=> $stable(frame_count_r))
    else $error("frame counter changed without a completed frame");

endmodule

[hdl/mwfp_out_stage.sv]
module mwfp_out_stage
  import mwfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  result_t      res,
  output logic         can_load,
  mwfp_result_if.source out_ch
);

  logic    valid_r;
  result_t res_r;

  assign can_load = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = valid_r;
  assign out_ch.payload_byte = res_r.payload_byte;
  assign out_ch.has_data     = res_r.has_data;
  assign out_ch.frame_end    = res_r.frame_end;
  assign out_ch.frame_number = res_r.frame_number;
  assign out_ch.source_id    = res_r.source;
  assign out_ch.kind         = res_r.kind;
  assign out_ch.frames_done  = res_r.frames_done;

endmodule

[hdl/magic_word_frame_parser.sv]
// Channel   Direction  Payload                                   Handshake
// in_ch     sink       data_byte                                 valid/ready
// out_ch    source     payload_byte, has_data, frame_end,        valid/ready
//                      frame_number, source_id, kind, frames_done
// cfg       sink       cfg_data (sync word)                      cfg_we, no wait
//
// One byte request is taken per cycle unless out_ch stalls a result; the byte is
// held in the input register and its result in the result register for out_ch.
// The input register and the result register each hold one request. A full result
// register stalled by out_ch holds back only a byte that produces a result, and
// new bytes wait behind that byte.
// Hunt and header bytes give no result, save an empty frame's last length byte.
// Reset is synchronous and active low; it clears the parser state and the sync word.
module magic_word_frame_parser
  import mwfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  mwfp_byte_if.sink         in_ch,
  mwfp_result_if.source     out_ch,
  input  logic              cfg_we,
  input  logic [WORD_W-1:0] cfg_data
);

  logic              in_valid_r;
  logic [BYTE_W-1:0] in_data_r;
  logic [WORD_W-1:0] sync_word_r;
  logic              res_valid;
  result_t           res;
  logic              can_load;
  step_ctrl_t        ctrl;

  assign ctrl.in_valid = in_valid_r;
  assign ctrl.step     = in_valid_r && (!res_valid || can_load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r <= SYNC_RESET;
    end else if (cfg_we) begin
      sync_word_r <= cfg_data;
    end
  end

  mwfp_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .step    (ctrl.step),
    .valid_r (in_valid_r),
    .data_r  (in_data_r)
  );

  mwfp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .data_byte (in_data_r),
    .sync_word (sync_word_r),
    .res_valid (res_valid),
    .res       (res)
  );

  mwfp_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (ctrl.step && res_valid),
    .res      (res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

[tb/testbench.sv]
module testbench;
  import mwfp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  // Byte-accurate model of the parser plus the queue of results it has predicted.
  class frame_checker;
    logic [WORD_W-1:0]  marker;
    logic [WORD_W-1:0]  hunt_window;
    logic [FILL_W-1:0]  hunt_fill;
    phase_t             stage;
    logic [FIDX_W-1:0]  byte_idx;
    logic [FRAME_W-1:0] frame_no;
    logic [BYTE_W-1:0]  src_id;
    logic [BYTE_W-1:0]  payload_kind;
    logic [WORD_W-1:0]  bytes_left;
    logic [WORD_W-1:0]  frames_completed;
    result_t            awaited[$];
    int                 errors;

    function new();
      marker           = SYNC_RESET;
      frame_no         = '0;
      src_id           = '0;
      payload_kind     = '0;
      bytes_left       = '0;
      frames_completed = '0;
      errors           = 0;
      restart_hunt();
    endfunction

    function void restart_hunt();
      hunt_window = '0;
      hunt_fill   = '0;
      stage       = PH_SEARCH;
      byte_idx    = '0;
    endfunction

    function void emit_result(logic [BYTE_W-1:0] b, logic has, logic last);
      result_t r;
      r.payload_byte = b;
      r.has_data     = has;
      r.frame_end    = last;
      r.frame_number = frame_no;
      r.source       = src_id;
      r.kind         = payload_kind;
      r.frames_done  = frames_completed;
      awaited.insert(awaited.size(), r);
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b);
      case (stage)
        PH_COUNT: begin
          if (byte_idx == 0) begin
            frame_no = {8'h00, b};
            byte_idx = 1;
          end else begin
            frame_no[15:8] = b;
            byte_idx       = 0;
            stage          = PH_SOURCE;
          end
        end
        PH_SOURCE: begin
          src_id = b;
          stage  = PH_KIND;
        end
        PH_KIND: begin
          payload_kind = b;
          stage        = PH_LENGTH;
          byte_idx     = 0;
        end
        PH_LENGTH: begin
          if (byte_idx == 0) bytes_left = {24'h0, b};
          else bytes_left = bytes_left | (WORD_W'(b) << (8 * byte_idx));
          if (byte_idx != FIDX_LAST) begin
            byte_idx++;
          end else begin
            byte_idx = 0;
            if (bytes_left == 0) begin
              frames_completed++;
              emit_result(8'h00, 1'b0, 1'b1);
              restart_hunt();
            end else begin
              stage = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          bytes_left--;
          if (bytes_left == 0) begin
            frames_completed++;
            emit_result(b, 1'b1, 1'b1);
            restart_hunt();
          end else begin
            emit_result(b, 1'b1, 1'b0);
          end
        end
        default: begin
          hunt_window = {b, hunt_window[WORD_W-1:8]};
          if (hunt_fill != FILL_FULL) begin
            hunt_fill++;
          end else if (hunt_window == marker) begin
            hunt_window = '0;
            hunt_fill   = '0;
            stage       = PH_COUNT;
            byte_idx    = 0;
          end
          if (stage != PH_COUNT) stage = PH_SEARCH;
        end
      endcase
    endfunction

    function string describe(result_t r);
      return $sformatf("byte %h data %b end %b frame %h src %h kind %h done %0d",
                       r.payload_byte, r.has_data, r.frame_end, r.frame_number,
                       r.source, r.kind, r.frames_done);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result: %s", describe(got));
        return;
      end
      want = awaited.pop_front();
      if (want.payload_byte !== got.payload_byte || want.has_data !== got.has_data ||
          want.frame_end !== got.frame_end || want.frame_number !== got.frame_number ||
          want.source !== got.source || want.kind !== got.kind ||
          want.frames_done !== got.frames_done) begin
        errors++;
        if (errors <= 10) begin
          $display("Result mismatch at %0t", $realtime);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [WORD_W-1:0] cfg_data;

  mwfp_byte_if   in_ch();
  mwfp_result_if out_ch();

  frame_checker sb;
  bit           idle_on = 1'b1;
  int           sent_count = 0;
  int           stall_left = 0;
  int           cycles = 0;

  magic_word_frame_parser u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    if (!idle_on || $urandom_range(0, 2) != 0) return 0;
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_clean(logic [WORD_W-1:0] w);
    logic [7:0] c;
    do c = 8'($urandom);
    while (c == w[7:0] || c == w[15:8] || c == w[23:16] || c == w[31:24]);
    return c;
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.payload_byte = out_ch.payload_byte;
        got.has_data     = out_ch.has_data;
        got.frame_end    = out_ch.frame_end;
        got.frame_number = out_ch.frame_number;
        got.source       = out_ch.source_id;
        got.kind         = out_ch.kind;
        got.frames_done  = out_ch.frames_done;
        sb.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.data_byte);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** magic_word_frame_parser: FAILED **");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk);
    while (!in_ch.ready);
    sent_count++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk);
    while (sb.awaited.size() != 0);
  endtask

  task automatic load_sync_word(input logic [WORD_W-1:0] w);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.marker = w;
  endtask

  // Noise never holds a full sync word: a partial sync prefix is always
  // followed by a byte that appears nowhere in the sync word.
  task automatic send_frame(input logic [WORD_W-1:0] w, input int noise_len,
                            input logic [15:0] fno, input logic [7:0] src,
                            input logic [7:0] knd, input logic [31:0] len);
    int p;
    for (int i = 0; i < noise_len; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        p = $urandom_range(1, 3);
        for (int k = 0; k < p; k++) send_byte(w[8*k +: 8]);
      end
      send_byte(pick_clean(w));
    end
    for (int k = 0; k < 4; k++) send_byte(w[8*k +: 8]);
    send_byte(fno[7:0]);
    send_byte(fno[15:8]);
    send_byte(src);
    send_byte(knd);
    for (int k = 0; k < 4; k++) send_byte(len[8*k +: 8]);
    for (int j = 0; j < len; j++) send_byte(8'($urandom));
  endtask

  task automatic run_random_phase(input logic [WORD_W-1:0] w, input int budget);
    int    stop_at;
    int    r;
    int    noise_len;
    logic [31:0] len;
    load_sync_word(w);
    stop_at = sent_count + budget;
    while (sent_count < stop_at) begin
      r = $urandom_range(0, 19);
      len = (r < 3) ? 0 : (r < 17) ? $urandom_range(1, 16) :
            (r < 19) ? $urandom_range(17, 64) : $urandom_range(200, 300);
      noise_len = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      send_frame(w, noise_len, 16'($urandom), 8'($urandom), 8'($urandom), len);
      if ($urandom_range(0, 7) == 0) drain_results();
    end
  endtask

  initial begin
    logic [7:0] rep;
    sb = new();
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The reset sync word of zero framing an empty payload with extreme header fields.
    send_frame(SYNC_RESET, 0, 16'hFFFF, 8'h00, 8'hFF, 32'd0);

    // The window has to slide past a false start before the sync word lines up.
    load_sync_word(32'h4433_2211);
    send_byte(8'h11);
    send_byte(8'h22);
    send_frame(32'h4433_2211, 0, 16'h0000, 8'hFF, 8'h00, 32'd1);

    run_random_phase(32'hFFFF_FFFF, 300);
    idle_on = 1'b0;
    run_random_phase(32'h0000_0000, 300);
    idle_on = 1'b1;
    run_random_phase(32'($urandom), 300);
    rep = 8'($urandom);
    run_random_phase({4{rep}}, 300);

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.awaited.size() != 0)
      $display("%0d expected results never arrived", sb.awaited.size());
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("** magic_word_frame_parser: PASSED **");
    end else begin
      $display("** magic_word_frame_parser: FAILED **");
    end
    $finish;
  end

endmodule
